// ===== src/bs_pkg.sv =====
// bitonic sorter package: shared width, reset value and lower limit of the size register
// no dependencies
`default_nettype none

package bs_pkg;

  // size register width and its reset value
  localparam int CFG_W = 3;

  typedef logic [CFG_W-1:0] lg_t;

  localparam lg_t SIZE_LOG2_RST = lg_t'(6);
  localparam lg_t MIN_LG        = lg_t'(1);

endpackage

`default_nettype wire

// ===== src/bs_if.sv =====
// valid/ready channel interfaces of the bitonic sorter: key input and sorted output
// no dependencies
`default_nettype none

// one key per beat into the sorter
interface bs_key_if #(
  parameter int KEY_WIDTH = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [KEY_WIDTH-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

// one sorted key per beat out of the sorter, last_key on the final one of a set
interface bs_out_if #(
  parameter int KEY_WIDTH = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [KEY_WIDTH-1:0] sorted_key;
  logic                        last_key;

  modport source (output valid, output sorted_key, output last_key, input ready);
  modport sink   (input valid, input sorted_key, input last_key, output ready);
endinterface

`default_nettype wire

// ===== src/bs_ram.sv =====
// simple dual-port key bank: one write port, one registered read port
// no dependencies
`default_nettype none

module bs_ram #(
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [2**AW];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/bitonic_sorter.sv =====
// bitonic sorter top level: load, in-memory bitonic network, ordered emit
// depends on bs_pkg, bs_if (bs_key_if, bs_out_if) and bs_ram
//
// Usage:
//   in_i carries signed keys, one per beat. Once 2^size_log2 keys have been
//   taken (size clamped to 1..log2 of the largest power of two <= DEPTH),
//   the set is sorted and sent on out_o in ascending order, one key per
//   beat, last_key high on its final key. in_i.ready is low from the end of
//   a set until its last key has moved into the output register.
//   cfg_we_i/cfg_wdata_i write size_log2 (reset value 6); write it only
//   while the block is idle.
// Phases for a set of n = 2^L keys:
//   load, sort with one bubble per network stage (the last one is the
//   flush cycle), then emit. The sort does one compare-exchange per
//   cycle; keys live in two banks split by index parity so both keys of
//   a pair are read in one cycle and written back in the next.
// Reset clears the load count and the sequencer, not the key banks.
// A stalled receiver holds the output register; reading of the banks
// waits, nothing is lost.
`default_nettype none

module bitonic_sorter
  import bs_pkg::*;
#(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  bs_key_if.sink           in_i,
  bs_out_if.source         out_o
);

  localparam int IW     = $clog2(DEPTH);
  localparam int NW     = IW + 1;
  localparam int BW     = (IW > 1) ? IW - 1 : 1;
  localparam int MAX_LG = $clog2(DEPTH + 1) - 1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_FLUSH,
    ST_EMIT
  } state_e;

  state_e              state_q;
  lg_t                 size_log2_q;
  logic [IW-1:0]       count_q;
  lg_t                 slg_q;
  lg_t                 dlg_q;
  logic [IW-1:0]       j_q;
  logic                bub_q;
  logic                cmp_v_q;
  logic                cmp_asc_q;
  logic                cmp_lo_par_q;
  logic [BW-1:0]       cmp_lo_a_q;
  logic [BW-1:0]       cmp_hi_a_q;
  logic [NW-1:0]       e_q;
  logic                pend_q;
  logic                pend_last_q;
  logic                pend_par_q;
  logic                ov_q;
  logic [KEY_WIDTH-1:0] okey_q;
  logic                olast_q;

  lg_t                 eff_lg;
  logic [NW-1:0]       n_set;
  logic [NW-1:0]       last_j_x;
  logic                last_pair;
  logic [NW-1:0]       jx;
  logic [NW-1:0]       lmask;
  logic [NW-1:0]       lo_x;
  logic [NW-1:0]       asc_sh;
  logic [IW-1:0]       lo;
  logic [IW-1:0]       hi;
  logic                lo_par;
  logic                asc;
  logic [BW-1:0]       lo_a;
  logic [BW-1:0]       hi_a;
  logic                sort_rd;
  logic                emit_rd;
  logic                emit_move;
  logic [IW-1:0]       e_idx;
  logic                ld_we;
  logic [BW-1:0]       ld_a;
  logic                ld_par;
  logic                re;
  logic [BW-1:0]       ra0;
  logic [BW-1:0]       ra1;
  logic [KEY_WIDTH-1:0] rd0;
  logic [KEY_WIDTH-1:0] rd1;
  logic [KEY_WIDTH-1:0] key_lo;
  logic [KEY_WIDTH-1:0] key_hi;
  logic                swap;
  logic [KEY_WIDTH-1:0] new_lo;
  logic [KEY_WIDTH-1:0] new_hi;
  logic                we0;
  logic                we1;
  logic [BW-1:0]       wa0;
  logic [BW-1:0]       wa1;
  logic [KEY_WIDTH-1:0] wd0;
  logic [KEY_WIDTH-1:0] wd1;

  // effective set size: clamp the register to 1..MAX_LG
  always_comb begin
    eff_lg = size_log2_q;
    if (eff_lg < MIN_LG) begin
      eff_lg = MIN_LG;
    end
    if (eff_lg > lg_t'(MAX_LG)) begin
      eff_lg = lg_t'(MAX_LG);
    end
  end

  assign n_set     = NW'(1) << eff_lg;
  assign last_j_x  = (n_set >> 1) - NW'(1);
  assign last_pair = (j_q == last_j_x[IW-1:0]);

  // pair index: insert a zero at bit dlg of the pair count
  assign jx     = {1'b0, j_q};
  assign lmask  = (NW'(1) << dlg_q) - NW'(1);
  assign lo_x   = ((jx << 1) & ~((lmask << 1) | NW'(1))) | (jx & lmask);
  assign lo     = lo_x[IW-1:0];
  assign hi     = lo | (IW'(1) << dlg_q);
  assign asc_sh = lo_x >> slg_q;
  assign asc    = ~asc_sh[0];
  assign lo_par = ^lo;
  assign lo_a   = BW'(lo >> 1);
  assign hi_a   = BW'(hi >> 1);

  // handshakes
  assign in_i.ready = (state_q == ST_LOAD);
  assign ld_we      = in_i.valid && in_i.ready;
  assign ld_a       = BW'(count_q >> 1);
  assign ld_par     = ^count_q;

  assign sort_rd   = (state_q == ST_SORT) && !bub_q;
  assign emit_move = pend_q && (!ov_q || out_o.ready);
  assign emit_rd   = (state_q == ST_EMIT) && (e_q < n_set) && (!pend_q || emit_move);
  assign e_idx     = e_q[IW-1:0];

  // read address selection: sort pair or emit index
  always_comb begin
    re  = sort_rd || emit_rd;
    ra0 = BW'(e_idx >> 1);
    ra1 = BW'(e_idx >> 1);
    if (sort_rd) begin
      ra0 = lo_par ? hi_a : lo_a;
      ra1 = lo_par ? lo_a : hi_a;
    end
  end

  // compare-exchange on the data read last cycle
  assign key_lo = cmp_lo_par_q ? rd1 : rd0;
  assign key_hi = cmp_lo_par_q ? rd0 : rd1;
  assign swap   = cmp_asc_q ? ($signed(key_lo) > $signed(key_hi))
                            : ($signed(key_hi) > $signed(key_lo));
  assign new_lo = swap ? key_hi : key_lo;
  assign new_hi = swap ? key_lo : key_hi;

  // write port selection: sort write-back or load
  always_comb begin
    if (cmp_v_q) begin
      we0 = swap;
      we1 = swap;
      wa0 = cmp_lo_par_q ? cmp_hi_a_q : cmp_lo_a_q;
      wa1 = cmp_lo_par_q ? cmp_lo_a_q : cmp_hi_a_q;
      wd0 = cmp_lo_par_q ? new_hi : new_lo;
      wd1 = cmp_lo_par_q ? new_lo : new_hi;
    end else begin
      we0 = ld_we && !ld_par;
      we1 = ld_we && ld_par;
      wa0 = ld_a;
      wa1 = ld_a;
      wd0 = in_i.key;
      wd1 = in_i.key;
    end
  end

  // key banks, even and odd index parity
  bs_ram #(.WIDTH(KEY_WIDTH), .AW(BW)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (wa0),
    .wdata_i (wd0),
    .re_i    (re),
    .raddr_i (ra0),
    .rdata_o (rd0)
  );

  bs_ram #(.WIDTH(KEY_WIDTH), .AW(BW)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (wa1),
    .wdata_i (wd1),
    .re_i    (re),
    .raddr_i (ra1),
    .rdata_o (rd1)
  );

  // control state and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      size_log2_q <= SIZE_LOG2_RST;
      count_q     <= '0;
      slg_q       <= MIN_LG;
      dlg_q       <= '0;
      j_q         <= '0;
      bub_q       <= 1'b0;
      cmp_v_q     <= 1'b0;
      e_q         <= '0;
      pend_q      <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_log2_q <= cfg_wdata_i;
      end
      cmp_v_q <= sort_rd;

      case (state_q)
        ST_LOAD: begin
          if (ld_we) begin
            if (({1'b0, count_q} + NW'(1)) >= n_set) begin
              count_q <= '0;
              state_q <= ST_SORT;
              slg_q   <= MIN_LG;
              dlg_q   <= '0;
              j_q     <= '0;
              bub_q   <= 1'b0;
            end else begin
              count_q <= count_q + IW'(1);
            end
          end
        end
        ST_SORT: begin
          if (bub_q) begin
            bub_q <= 1'b0;
          end else if (last_pair) begin
            // end of a network stage: let the write-back land first
            j_q   <= '0;
            bub_q <= 1'b1;
            if (dlg_q == '0) begin
              if (slg_q == eff_lg) begin
                state_q <= ST_FLUSH;
              end else begin
                slg_q <= slg_q + lg_t'(1);
                dlg_q <= slg_q;
              end
            end else begin
              dlg_q <= dlg_q - lg_t'(1);
            end
          end else begin
            j_q <= j_q + IW'(1);
          end
        end
        ST_FLUSH: begin
          state_q <= ST_EMIT;
          e_q     <= '0;
          bub_q   <= 1'b0;
        end
        ST_EMIT: begin
          if (emit_move && pend_last_q) begin
            state_q <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase

      // emit read pipeline and output register
      if (emit_rd) begin
        e_q    <= e_q + NW'(1);
        pend_q <= 1'b1;
      end else if (emit_move) begin
        pend_q <= 1'b0;
      end
      if (emit_move) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // payload registers of the compare stage and emit path
  always_ff @(posedge clk_i) begin
    if (sort_rd) begin
      cmp_asc_q    <= asc;
      cmp_lo_par_q <= lo_par;
      cmp_lo_a_q   <= lo_a;
      cmp_hi_a_q   <= hi_a;
    end
    if (emit_rd) begin
      pend_last_q <= (e_q == (n_set - NW'(1)));
      pend_par_q  <= ^e_idx;
    end
    if (emit_move) begin
      okey_q  <= pend_par_q ? rd1 : rd0;
      olast_q <= pend_last_q;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.sorted_key = okey_q;
  assign out_o.last_key   = olast_q;

`ifndef ASSERT_OFF
  // a pair read never hits an entry whose write-back is still in flight
  a_no_rw_hazard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmp_v_q && sort_rd) |-> ((ra0 != wa0) && (ra1 != wa1)))
    else $error("sort read overlaps pending write-back");

  // write-back only happens during the sort or its flush cycle
  a_cmp_in_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_v_q |-> ((state_q == ST_SORT) || (state_q == ST_FLUSH)))
    else $error("compare stage active outside sort");

  // a pending emit read only exists while emitting
  a_pend_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_EMIT))
    else $error("emit read pending outside emit");

  // emit index never runs past the set
  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (e_q <= n_set))
    else $error("emit index beyond set size");
`endif

endmodule

`default_nettype wire
